// ===== sv/tba_pkg.sv =====
`default_nettype none

package tba_pkg;

   localparam int NUM_BLOCKS = 32768;
   localparam int TAG_W      = 4;
   localparam int WORD_TAGS  = 16;
   localparam int WORD_W     = TAG_W * WORD_TAGS;
   localparam int WORDS      = (NUM_BLOCKS + WORD_TAGS - 1) / WORD_TAGS;
   localparam int ADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(WORDS - 1);
   localparam logic [4:0]        LAST_LANES = 5'(NUM_BLOCKS - (WORDS - 1) * WORD_TAGS);
   localparam logic [16:0]       POOL_SIZE  = 17'(NUM_BLOCKS);
   localparam logic [15:0]       NO_BLOCK   = 16'hFFFF;

   localparam logic [2:0] OP_ALLOC     = 3'd0;
   localparam logic [2:0] OP_FREE      = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_SET       = 3'd3;
   localparam logic [2:0] OP_FIND_LAST = 3'd4;

   typedef struct packed {
      logic [2:0]       op;
      logic [15:0]      block_index;
      logic [TAG_W-1:0] block_type;
   } req_type;

   typedef struct packed {
      logic [15:0]      result_index;
      logic [TAG_W-1:0] result_type;
      logic             found;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] lane;
   } match_type;

endpackage

`default_nettype wire

// ===== sv/typed_block_allocator.sv =====
`default_nettype none

// channel  | ports                    | beat taken when
// ---------+--------------------------+-----------------------
// request  | start, busy, req_item    | start high, busy low
// response | rsp_strobe, rsp_item     | rsp_strobe high (one cycle)
//
// Tags live 16 to a 64-bit word in one RAM. Allocate and find-last read one
// word per cycle through a single match unit; busy stays high until the
// response beat. Read, free and set answer through ST_ACCESS; a bad index
// or unused op is answered straight from ST_IDLE.
// After reset a clearing pass writes WORDS words with busy high.
// Responses cannot be stalled.
module typed_block_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tba_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output tba_pkg::rsp_type      rsp_item
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ACCESS
   } state_type;

   state_type                      state_ff, state_in;
   logic [2:0]                     op_ff, op_in;
   logic [tba_pkg::TAG_W-1:0]      tag_ff, tag_in;
   logic [3:0]                     lane_ff, lane_in;
   logic [tba_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [tba_pkg::ADDR_W-1:0]     cur_ff, cur_in;
   logic                           lag_ff, lag_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   tba_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           we;
   logic [tba_pkg::ADDR_W-1:0]     waddr, raddr, final_word;
   logic [tba_pkg::WORD_W-1:0]     wdata, rdata, mod_word;
   logic [3:0]                     sel_lane;
   logic [tba_pkg::TAG_W-1:0]      new_tag, scan_tag;
   logic                           accept, upward, in_pool;
   tba_pkg::match_type             match;

   tba_tag_ram u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   tba_match u_match (
      .word      (rdata),
      .word_addr (cur_ff),
      .tag       (scan_tag),
      .upward    (upward),
      .res       (match)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign upward     = (op_ff == tba_pkg::OP_ALLOC);
   assign final_word = upward ? tba_pkg::LAST_WORD : '0;
   assign in_pool    = ({1'b0, req_item.block_index} < tba_pkg::POOL_SIZE);
   assign sel_lane   = (state_ff == ST_ACCESS) ? lane_ff : match.lane;
   assign new_tag    = (op_ff == tba_pkg::OP_FREE) ? '0 : tag_ff;
   // allocate hunts for a free tag, find-last for the requested one
   assign scan_tag   = upward ? '0 : tag_ff;

   always_comb begin
      mod_word = rdata;
      mod_word[sel_lane*tba_pkg::TAG_W +: tba_pkg::TAG_W] = new_tag;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      lane_in       = lane_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      lag_in        = lag_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      we            = 1'b0;
      waddr         = addr_ff;
      wdata         = '0;
      raddr         = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            if (addr_ff == tba_pkg::LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            raddr = req_item.block_index[tba_pkg::ADDR_W+3:4];
            if (accept) begin
               op_in   = req_item.op;
               tag_in  = req_item.block_type;
               lane_in = req_item.block_index[3:0];
               lag_in  = 1'b0;
               case (req_item.op)
                  tba_pkg::OP_ALLOC: begin
                     addr_in  = '0;
                     state_in = ST_SCAN;
                  end
                  tba_pkg::OP_FIND_LAST: begin
                     addr_in  = tba_pkg::LAST_WORD;
                     state_in = ST_SCAN;
                  end
                  tba_pkg::OP_FREE, tba_pkg::OP_READ, tba_pkg::OP_SET: begin
                     if (in_pool) begin
                        addr_in  = req_item.block_index[tba_pkg::ADDR_W+3:4];
                        state_in = ST_ACCESS;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '{tba_pkg::NO_BLOCK, '0, 1'b0};
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{tba_pkg::NO_BLOCK, '0, 1'b0};
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (op_ff == tba_pkg::OP_READ) begin
               rsp_in = '{tba_pkg::NO_BLOCK,
                          rdata[lane_ff*tba_pkg::TAG_W +: tba_pkg::TAG_W], 1'b0};
            end else begin
               we     = 1'b1;
               wdata  = mod_word;
               rsp_in = '{tba_pkg::NO_BLOCK, '0, 1'b0};
            end
         end
         ST_SCAN: begin
            cur_in = addr_ff;
            lag_in = 1'b1;
            if (addr_ff != final_word) begin
               addr_in = upward ? addr_ff + 1'b1 : addr_ff - 1'b1;
            end
            if (lag_ff) begin
               if (match.hit) begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{16'({cur_ff, match.lane}), '0, 1'b1};
                  if (upward) begin
                     we    = 1'b1;
                     waddr = cur_ff;
                     wdata = mod_word;
                  end
               end else if (cur_ff == final_word) begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{tba_pkg::NO_BLOCK, '0, 1'b0};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         lag_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         lag_ff        <= lag_in;
         rsp_strobe_ff <= rsp_strobe_in;
         op_ff         <= op_in;
         tag_ff        <= tag_in;
         lane_ff       <= lane_in;
         cur_ff        <= cur_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_strobe_ff)
      else $error("response during clearing pass");

   a_found_in_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.found) |-> ({1'b0, rsp_ff.result_index} < tba_pkg::POOL_SIZE))
      else $error("found index outside pool");

   a_type_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_ff.result_type != '0)) |-> (op_ff == tba_pkg::OP_READ))
      else $error("tag returned for non-read op");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff != ST_IDLE))
      else $error("tag write while idle");

   a_scan_ends_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && rsp_strobe_in) |=> (state_ff == ST_IDLE))
      else $error("scan response without return to idle");
`endif

endmodule

`default_nettype wire

// ===== sv/tba_tag_ram.sv =====
`default_nettype none

module tba_tag_ram (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [tba_pkg::ADDR_W-1:0] waddr,
   input  wire logic [tba_pkg::WORD_W-1:0] wdata,
   input  wire logic [tba_pkg::ADDR_W-1:0] raddr,
   output logic      [tba_pkg::WORD_W-1:0] rdata
);

   logic [tba_pkg::WORD_W-1:0] mem [tba_pkg::WORDS];
   logic [tba_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/tba_match.sv =====
`default_nettype none

// first or last lane of a tag word whose tag equals the target
module tba_match (
   input  wire logic [tba_pkg::WORD_W-1:0] word,
   input  wire logic [tba_pkg::ADDR_W-1:0] word_addr,
   input  wire logic [tba_pkg::TAG_W-1:0]  tag,
   input  wire logic                       upward,
   output tba_pkg::match_type              res
);

   logic [tba_pkg::WORD_TAGS-1:0] hits;

   always_comb begin
      for (int i = 0; i < tba_pkg::WORD_TAGS; i++) begin
         hits[i] = (word[i*tba_pkg::TAG_W +: tba_pkg::TAG_W] == tag) &&
                   ((word_addr != tba_pkg::LAST_WORD) || (5'(i) < tba_pkg::LAST_LANES));
      end
   end

   always_comb begin
      res.hit  = |hits;
      res.lane = '0;
      if (upward) begin
         for (int i = tba_pkg::WORD_TAGS - 1; i >= 0; i--) begin
            if (hits[i]) begin
               res.lane = 4'(i);
            end
         end
      end else begin
         for (int i = 0; i < tba_pkg::WORD_TAGS; i++) begin
            if (hits[i]) begin
               res.lane = 4'(i);
            end
         end
      end
   end

endmodule

`default_nettype wire
